@@ hw/rtl/mfi_pkg.sv @@
package mfi_pkg;

    // number format and network limits
    localparam int DATA_W     = 16;
    localparam int FRAC_BITS  = 12;
    localparam int MAX_LAYERS = 4;
    localparam int MAX_NODES  = 16;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 5;
    localparam int LAY_W      = 2;

    // shared unit widths
    localparam int OPND_W = DATA_W + 1;
    localparam int PROD_W = 2 * OPND_W;
    localparam int ACC_W  = 40;
    localparam int QUO_W  = FRAC_BITS - 1;

    localparam logic [DATA_W-1:0] ACT_ONE  = DATA_W'(1 << FRAC_BITS);
    localparam logic [DATA_W-1:0] ACT_HALF = DATA_W'(1 << (FRAC_BITS - 1));

    // opcodes
    localparam logic [2:0] OP_WEIGHT  = 3'd0;
    localparam logic [2:0] OP_BIAS    = 3'd1;
    localparam logic [2:0] OP_INPUT   = 3'd2;
    localparam logic [2:0] OP_TARGET  = 3'd3;
    localparam logic [2:0] OP_COMPUTE = 3'd4;
    localparam logic [2:0] OP_COST    = 3'd5;

    // register indexes
    localparam logic [2:0] REG_LAYER_COUNT = 3'd0;
    localparam logic [2:0] REG_INPUT_WIDTH = 3'd1;
    localparam logic [2:0] REG_WIDTH_ONE   = 3'd2;
    localparam logic [2:0] REG_WIDTH_TWO   = 3'd3;
    localparam logic [2:0] REG_WIDTH_THREE = 3'd4;
    localparam logic [2:0] REG_WIDTH_FOUR  = 3'd5;

    localparam logic RK_ELEMENT = 1'b0;
    localparam logic RK_COST    = 1'b1;

    typedef struct packed {
        logic [2:0]               opcode;
        logic [1:0]               layer_sel;
        logic [3:0]               row_sel;
        logic [3:0]               col_sel;
        logic signed [DATA_W-1:0] value;
        logic                     run_all;
        logic [2:0]               layers_to_run;
    } t_in_item;

    typedef struct packed {
        logic                     result_kind;
        logic [3:0]               element_index;
        logic signed [DATA_W-1:0] element_value;
        logic [31:0]              total_cost;
        logic                     last;
    } t_out_item;

    // sequencer to shared unit
    typedef struct packed {
        logic acc_clr;
        logic mul_en;
        logic act_start;
    } t_unit_ctl;

    // shared unit to sequencer
    typedef struct packed {
        logic mac_busy;
        logic act_busy;
    } t_unit_sts;

endpackage

@@ hw/rtl/mfi_ram.sv @@
module mfi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/mfi_unit.sv @@
module mfi_unit (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  mfi_pkg::t_unit_ctl                      i_ctl,
    input  logic signed [mfi_pkg::OPND_W-1:0]       i_op_a,
    input  logic signed [mfi_pkg::OPND_W-1:0]       i_op_b,
    input  logic signed [mfi_pkg::DATA_W-1:0]       i_bias,
    output mfi_pkg::t_unit_sts                      o_sts,
    output logic signed [mfi_pkg::ACC_W-1:0]        o_acc,
    output logic signed [mfi_pkg::DATA_W-1:0]       o_y
);
    import mfi_pkg::*;

    localparam int SUM_W = ACC_W - FRAC_BITS + 1;
    localparam int MAG_W = DATA_W + 1;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_v;
    logic signed [ACC_W-1:0]  r_acc;
    logic [MAG_W-1:0]         r_rem;
    logic [MAG_W-1:0]         r_den;
    logic [QUO_W-1:0]         r_q;
    logic                     r_neg;
    logic [3:0]               r_cnt;

    logic signed [ACC_W-1:0]  w_shr;
    logic signed [SUM_W-1:0]  w_sum;
    logic signed [DATA_W-1:0] w_x;
    logic [MAG_W-1:0]         w_mag;
    logic [MAG_W:0]           w_trial;
    logic                     w_fit;

    // floor shift, bias add, saturate to data width
    always_comb begin
        w_shr = r_acc >>> FRAC_BITS;
        w_sum = SUM_W'(w_shr) + SUM_W'(i_bias);
        if (w_sum > SUM_W'(signed'({1'b0, {(DATA_W-1){1'b1}}}))) begin
            w_x = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (w_sum < -SUM_W'(signed'({1'b0, {(DATA_W-1){1'b1}}})) - SUM_W'(1)) begin
            w_x = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            w_x = w_sum[DATA_W-1:0];
        end
        w_mag = w_x[DATA_W-1] ? MAG_W'(-MAG_W'(w_x)) : MAG_W'(w_x);
    end

    // restoring divide step: one quotient bit per cycle
    assign w_trial = {r_rem, 1'b0};
    assign w_fit   = (w_trial >= {1'b0, r_den});

    // multiply then accumulate, a register after the product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
        end else begin
            r_prod_v <= i_ctl.mul_en;
        end
        r_prod <= i_op_a * i_op_b;
        if (i_ctl.acc_clr) begin
            r_acc <= '0;
        end else if (r_prod_v) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // squash: q = half*|x| / (one+|x|), starting with the high part of the dividend
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.act_start) begin
            r_cnt <= 4'(QUO_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 4'd1;
        end
        if (i_ctl.act_start) begin
            r_rem <= w_mag;
            r_den <= MAG_W'(ACT_ONE) + w_mag;
            r_neg <= w_x[DATA_W-1];
            r_q   <= '0;
        end else if (r_cnt != '0) begin
            r_rem <= w_fit ? MAG_W'(w_trial - {1'b0, r_den}) : w_trial[MAG_W-1:0];
            r_q   <= {r_q[QUO_W-2:0], w_fit};
        end
    end

    assign o_y = r_neg ? signed'(ACT_HALF - DATA_W'(r_q)) : signed'(ACT_HALF + DATA_W'(r_q));
    assign o_acc = r_acc;
    assign o_sts.mac_busy = r_prod_v;
    assign o_sts.act_busy = (r_cnt != '0);

endmodule

@@ hw/rtl/mlp_forward_inference.sv @@
// Fixed-point feed-forward network inference (Q4.12, up to 4 layers of 16 nodes).
// Input channel: i_in_valid / o_in_ready carry one t_in_item per transfer. Weight,
// bias, input and target loads produce no result. A compute item
// emits the result vector, one t_out_item per element, with last on the final one;
// a cost item emits one item holding the Q16.16 sum of squared errors, running all
// layers first when the input vector changed since the last run.
// Configuration goes through the APB port (register i at byte address 4*i) and is
// to be written only while the block is idle; the block itself does not enforce it.
// The nodes of each layer are computed in turn by one multiplier/accumulator and
// an 11-step divider that are shared by all nodes. Each emitted element waits for
// the receiver to take it; a cost item adds one more pass over its n elements.
// One item is processed at a time: o_in_ready is high only when idle, which
// includes waiting until every result of the item has been taken by the receiver.
// Reset clears the registers to 1, the result as not fresh and the output as empty;
// the weight, bias and vector stores hold no reset value.
module mlp_forward_inference (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mfi_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output mfi_pkg::t_out_item o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import mfi_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_L_START = 4'd1;
    localparam logic [3:0] S_N_START = 4'd2;
    localparam logic [3:0] S_N_MAC   = 4'd3;
    localparam logic [3:0] S_N_DRAIN = 4'd4;
    localparam logic [3:0] S_N_ACT   = 4'd5;
    localparam logic [3:0] S_N_DIV   = 4'd6;
    localparam logic [3:0] S_R_END   = 4'd7;
    localparam logic [3:0] S_E_RD    = 4'd8;
    localparam logic [3:0] S_E_LD    = 4'd9;
    localparam logic [3:0] S_E_WT    = 4'd10;
    localparam logic [3:0] S_C_START = 4'd11;
    localparam logic [3:0] S_C_MAC   = 4'd12;
    localparam logic [3:0] S_C_DRAIN = 4'd13;
    localparam logic [3:0] S_C_LD    = 4'd14;
    localparam logic [3:0] S_C_WT    = 4'd15;

    localparam int WADDR_W = LAY_W + 2 * IDX_W;
    localparam int BADDR_W = LAY_W + IDX_W;
    localparam int AADDR_W = 1 + IDX_W;

    // registers and state
    logic [2:0]       r_layer_count;
    logic [CNT_W-1:0] r_width [MAX_LAYERS+1];
    logic [3:0]       r_state;
    logic [2:0]       r_l;
    logic [2:0]       r_nl;
    logic [CNT_W-1:0] r_i;
    logic [CNT_W-1:0] r_j;
    logic [CNT_W-1:0] r_len;
    logic [CNT_W-1:0] r_outn;
    logic [CNT_W-1:0] r_n_cost;
    logic             r_cur;
    logic             r_src_in;
    logic             r_is_cost;
    logic [CNT_W-1:0] r_res_len;
    logic             r_res_in;
    logic             r_res_sel;
    logic             r_fresh;
    logic             r_rd_v;
    logic             r_rd_z;
    logic             r_out_valid;
    t_out_item        r_out;

    logic             w_in_acc;
    logic             w_cfg_we;
    logic [2:0]       w_eff;
    logic [2:0]       w_want;
    logic [2:0]       w_nl;
    logic             w_cost_phase;
    logic             w_drained;

    logic [DATA_W-1:0] w_w_q, w_b_q, w_in_q, w_tg_q, w_act_q;
    logic              w_act_rsel;
    logic              w_act_we;
    logic signed [DATA_W-1:0] w_src;
    logic signed [DATA_W-1:0] w_res;
    logic signed [OPND_W-1:0] w_diff;
    logic signed [OPND_W-1:0] w_op_a, w_op_b;
    t_unit_ctl         w_ctl;
    t_unit_sts         w_sts;
    logic signed [ACC_W-1:0]  w_acc;
    logic signed [DATA_W-1:0] w_y;

    function automatic logic [CNT_W-1:0] clamp_nodes(input logic [CNT_W-1:0] v);
        if (v == '0) begin
            return CNT_W'(1);
        end else if (v > CNT_W'(MAX_NODES)) begin
            return CNT_W'(MAX_NODES);
        end
        return v;
    endfunction

    assign w_in_acc = i_in_valid && o_in_ready;
    assign w_cfg_we = psel && penable && pwrite;
    assign pready   = 1'b1;

    // effective layer count and layers to run
    always_comb begin
        if (r_layer_count == '0) begin
            w_eff = 3'd1;
        end else if (r_layer_count > 3'(MAX_LAYERS)) begin
            w_eff = 3'(MAX_LAYERS);
        end else begin
            w_eff = r_layer_count;
        end
        w_want = i_in_data.run_all ? w_eff : i_in_data.layers_to_run;
        w_nl   = (w_want < w_eff) ? w_want : w_eff;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer_count <= 3'd1;
            for (int k = 0; k <= MAX_LAYERS; k++) begin
                r_width[k] <= CNT_W'(1);
            end
        end else if (w_cfg_we) begin
            case (paddr[4:2])
                REG_LAYER_COUNT: r_layer_count <= pwdata[2:0];
                REG_INPUT_WIDTH: r_width[0] <= pwdata[CNT_W-1:0];
                REG_WIDTH_ONE:   r_width[1] <= pwdata[CNT_W-1:0];
                REG_WIDTH_TWO:   r_width[2] <= pwdata[CNT_W-1:0];
                REG_WIDTH_THREE: r_width[3] <= pwdata[CNT_W-1:0];
                REG_WIDTH_FOUR:  r_width[4] <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_LAYER_COUNT: prdata = 32'(r_layer_count);
            REG_INPUT_WIDTH: prdata = 32'(r_width[0]);
            REG_WIDTH_ONE:   prdata = 32'(r_width[1]);
            REG_WIDTH_TWO:   prdata = 32'(r_width[2]);
            REG_WIDTH_THREE: prdata = 32'(r_width[3]);
            REG_WIDTH_FOUR:  prdata = 32'(r_width[4]);
            default:         prdata = '0;
        endcase
    end

    // stores
    mfi_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LAYERS * MAX_NODES * MAX_NODES)) u_weight (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && i_in_data.opcode == OP_WEIGHT),
        .i_waddr ({i_in_data.layer_sel, i_in_data.row_sel, i_in_data.col_sel}),
        .i_wdata (i_in_data.value),
        .i_raddr (WADDR_W'({r_l[LAY_W-1:0], r_i[IDX_W-1:0], r_j[IDX_W-1:0]})),
        .o_rdata (w_w_q)
    );

    mfi_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LAYERS * MAX_NODES)) u_bias (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && i_in_data.opcode == OP_BIAS),
        .i_waddr ({i_in_data.layer_sel, i_in_data.row_sel}),
        .i_wdata (i_in_data.value),
        .i_raddr (BADDR_W'({r_l[LAY_W-1:0], r_i[IDX_W-1:0]})),
        .o_rdata (w_b_q)
    );

    mfi_ram #(.WIDTH(DATA_W), .DEPTH(MAX_NODES)) u_input (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && i_in_data.opcode == OP_INPUT),
        .i_waddr (i_in_data.row_sel),
        .i_wdata (i_in_data.value),
        .i_raddr (r_j[IDX_W-1:0]),
        .o_rdata (w_in_q)
    );

    mfi_ram #(.WIDTH(DATA_W), .DEPTH(MAX_NODES)) u_target (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && i_in_data.opcode == OP_TARGET),
        .i_waddr (i_in_data.row_sel),
        .i_wdata (i_in_data.value),
        .i_raddr (r_j[IDX_W-1:0]),
        .o_rdata (w_tg_q)
    );

    // two activation buffers, ping-pong by layer
    assign w_act_rsel = (r_state == S_N_MAC) ? r_cur : r_res_sel;
    assign w_act_we   = (r_state == S_N_DIV) && !w_sts.act_busy;

    mfi_ram #(.WIDTH(DATA_W), .DEPTH(2 * MAX_NODES)) u_act (
        .i_clk   (i_clk),
        .i_we    (w_act_we),
        .i_waddr (AADDR_W'({~r_cur, r_i[IDX_W-1:0]})),
        .i_wdata (w_y),
        .i_raddr (AADDR_W'({w_act_rsel, r_j[IDX_W-1:0]})),
        .o_rdata (w_act_q)
    );

    // operand selection for the shared unit
    assign w_cost_phase = (r_state == S_C_MAC) || (r_state == S_C_DRAIN);
    assign w_src  = r_src_in ? signed'(w_in_q) : signed'(w_act_q);
    assign w_res  = r_rd_z ? '0 : (r_res_in ? signed'(w_in_q) : signed'(w_act_q));
    assign w_diff = OPND_W'(w_res) - OPND_W'(signed'(w_tg_q));
    assign w_op_a = w_cost_phase ? w_diff : OPND_W'(signed'(w_w_q));
    assign w_op_b = w_cost_phase ? w_diff : OPND_W'(w_src);

    assign w_ctl.acc_clr   = (r_state == S_N_START) || (r_state == S_C_START);
    assign w_ctl.mul_en    = r_rd_v;
    assign w_ctl.act_start = (r_state == S_N_ACT);
    assign w_drained       = !r_rd_v && !w_sts.mac_busy;

    mfi_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_op_a  (w_op_a),
        .i_op_b  (w_op_b),
        .i_bias  (signed'(w_b_q)),
        .o_sts   (w_sts),
        .o_acc   (w_acc),
        .o_y     (w_y)
    );

    // read issue pipeline tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
        end else begin
            r_rd_v <= (r_state == S_N_MAC) || (r_state == S_C_MAC);
        end
        r_rd_z <= (r_j >= r_res_len);
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fresh     <= 1'b0;
            r_res_len   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_l      <= '0;
                        r_len    <= clamp_nodes(r_width[0]);
                        r_cur    <= 1'b0;
                        r_src_in <= 1'b1;
                        case (i_in_data.opcode)
                            OP_INPUT: r_fresh <= 1'b0;
                            OP_COMPUTE: begin
                                r_is_cost <= 1'b0;
                                r_nl      <= w_nl;
                                r_state   <= (w_nl == '0) ? S_R_END : S_L_START;
                            end
                            OP_COST: begin
                                r_is_cost <= 1'b1;
                                r_nl      <= w_eff;
                                r_state   <= r_fresh ? S_C_START : S_L_START;
                            end
                            default: ;
                        endcase
                    end
                end
                S_L_START: begin
                    r_outn  <= clamp_nodes(r_width[r_l + 3'd1]);
                    r_i     <= '0;
                    r_state <= S_N_START;
                end
                S_N_START: begin
                    r_j     <= '0;
                    r_state <= S_N_MAC;
                end
                S_N_MAC: begin
                    r_j <= r_j + CNT_W'(1);
                    if (r_j == r_len - CNT_W'(1)) begin
                        r_state <= S_N_DRAIN;
                    end
                end
                S_N_DRAIN: begin
                    if (w_drained) begin
                        r_state <= S_N_ACT;
                    end
                end
                S_N_ACT: r_state <= S_N_DIV;
                S_N_DIV: begin
                    if (!w_sts.act_busy) begin
                        if (r_i == r_outn - CNT_W'(1)) begin
                            r_cur    <= ~r_cur;
                            r_len    <= r_outn;
                            r_src_in <= 1'b0;
                            r_l      <= r_l + 3'd1;
                            r_state  <= (r_l + 3'd1 == r_nl) ? S_R_END : S_L_START;
                        end else begin
                            r_i     <= r_i + CNT_W'(1);
                            r_state <= S_N_START;
                        end
                    end
                end
                S_R_END: begin
                    r_res_len <= r_len;
                    r_res_in  <= r_src_in;
                    r_res_sel <= r_cur;
                    r_fresh   <= 1'b1;
                    r_j       <= '0;
                    r_state   <= r_is_cost ? S_C_START : S_E_RD;
                end
                S_E_RD: r_state <= S_E_LD;
                S_E_LD: begin
                    r_out.result_kind   <= RK_ELEMENT;
                    r_out.element_index <= r_j[IDX_W-1:0];
                    r_out.element_value <= w_res;
                    r_out.total_cost    <= '0;
                    r_out.last          <= (r_j == r_res_len - CNT_W'(1));
                    r_out_valid         <= 1'b1;
                    r_state             <= S_E_WT;
                end
                S_E_WT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        if (r_out.last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_j     <= r_j + CNT_W'(1);
                            r_state <= S_E_RD;
                        end
                    end
                end
                S_C_START: begin
                    r_j      <= '0;
                    r_n_cost <= clamp_nodes(r_width[w_eff]);
                    r_state  <= S_C_MAC;
                end
                S_C_MAC: begin
                    r_j <= r_j + CNT_W'(1);
                    if (r_j == r_n_cost - CNT_W'(1)) begin
                        r_state <= S_C_DRAIN;
                    end
                end
                S_C_DRAIN: begin
                    if (w_drained) begin
                        r_state <= S_C_LD;
                    end
                end
                S_C_LD: begin
                    // squares sum in Q24, report Q16.16
                    r_out.result_kind   <= RK_COST;
                    r_out.element_index <= '0;
                    r_out.element_value <= '0;
                    r_out.total_cost    <= w_acc[2*FRAC_BITS-16+31:2*FRAC_BITS-16];
                    r_out.last          <= 1'b1;
                    r_out_valid         <= 1'b1;
                    r_state             <= S_C_WT;
                end
                S_C_WT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
